>>> hw/rtl/pec15_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PEC-15 package
// Widths, reset constants and the byte-wise CRC-15 update for the PEC unit.
// ----------------------------------------------------------------------------
package pec15_pkg;

   localparam int CRC_W  = 15;
   localparam int BYTE_W = 8;
   localparam int PEC_W  = 16;

   localparam logic [CRC_W-1:0] CRC_POLY       = 15'h4599;
   localparam logic [CRC_W-1:0] SEED_RESET_VAL = 15'd16;

   // Segment operation, sampled on the first byte of a segment.
   localparam logic OP_GENERATE = 1'b0;
   localparam logic OP_CHECK    = 1'b1;

   typedef logic [CRC_W-1:0]  crc_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // One byte is folded in at bit 7, followed by eight polynomial steps.
   function automatic crc_type crc_byte_update(input crc_type crc, input byte_type data);
      crc_type c;
      c = crc ^ {data, 7'd0};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pec15_frame_generate_check_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PEC-15 frame generate / check unit
// Streams segment bytes, appends the PEC in generate mode and checks the
// trailing PEC in check mode.
// ----------------------------------------------------------------------------
// An input transfer passes the input register, then the result register,
// before its byte appears at the output.
// Throughput: one byte per cycle while rsp_ready allows; after the last byte
// of a generate-mode segment, input waits while both PEC bytes go out.
// Reset (synchronous): flushes both stages, empties the PEC queue, starts a
// new segment and loads the seed register with its reset value of 16.
module pec15_frame_generate_check_unit (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire  [7:0]             req_data_byte,
   input  wire                    req_last_byte,
   input  wire                    req_operation,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_pec_byte,
   output logic                   rsp_out_last,
   output logic                   rsp_pec_fault,
   input  wire                    csr_we,
   input  wire  [14:0]            csr_wdata
);
   import pec15_pkg::*;

   // Configuration.
   crc_type  seed_ff;

   // Input stage.
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff;
   logic     in_last_ff;
   logic     in_op_ff;

   // Segment state.
   crc_type  crc_now_ff, crc_now_in;
   crc_type  crc_back_one_ff, crc_back_one_in;
   byte_type held_byte_ff;
   logic [1:0] bytes_seen_ff, bytes_seen_in;
   logic     mode_ff, mode_in;

   // PEC bytes still to be sent after a generate-mode segment.
   logic [1:0]       pend_cnt_ff, pend_cnt_in;
   logic [PEC_W-1:0] pend_pec_ff, pend_pec_in;

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   byte_type rsp_byte_ff, rsp_byte_in;
   logic     rsp_pec_ff, rsp_pec_in;
   logic     rsp_last_ff, rsp_last_in;
   logic     rsp_err_ff, rsp_err_in;

   logic     out_free;
   logic     in_move;
   logic     seg_start;
   logic     cur_mode;
   crc_type  crc_base;
   crc_type  crc_next;
   logic     mismatch;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_move   = in_valid_ff && out_free && (pend_cnt_ff == 2'd0);
   assign req_ready = !in_valid_ff || in_move;

   assign seg_start = (bytes_seen_ff == 2'd0);
   assign cur_mode  = seg_start ? in_op_ff : mode_ff;
   assign crc_base  = seg_start ? seed_ff : crc_now_ff;
   assign crc_next  = crc_byte_update(crc_base, in_byte_ff);

   // The received PEC is the held byte and this one; it is compared with the
   // PEC over everything before those two bytes.
   assign mismatch = (bytes_seen_ff < 2'd2) ||
                     ({crc_back_one_ff, 1'b0} != {held_byte_ff, in_byte_ff});

   always_comb begin
      in_valid_in     = in_valid_ff;
      crc_now_in      = crc_now_ff;
      crc_back_one_in = crc_back_one_ff;
      bytes_seen_in   = bytes_seen_ff;
      mode_in         = mode_ff;
      pend_cnt_in     = pend_cnt_ff;
      pend_pec_in     = pend_pec_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_byte_in     = rsp_byte_ff;
      rsp_pec_in      = rsp_pec_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_err_in      = rsp_err_ff;

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end

      if (out_free) begin
         if (pend_cnt_ff != 2'd0) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = pend_pec_ff[PEC_W-1 -: BYTE_W];
            rsp_pec_in   = 1'b1;
            rsp_last_in  = (pend_cnt_ff == 2'd1);
            rsp_err_in   = 1'b0;
            pend_pec_in  = {pend_pec_ff[BYTE_W-1:0], {BYTE_W{1'b0}}};
            pend_cnt_in  = pend_cnt_ff - 2'd1;
         end else if (in_move) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = in_byte_ff;
            rsp_pec_in   = 1'b0;
            rsp_last_in  = in_last_ff && (cur_mode != OP_GENERATE);
            rsp_err_in   = in_last_ff && (cur_mode != OP_GENERATE) && mismatch;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end

      if (in_move) begin
         mode_in         = cur_mode;
         crc_back_one_in = crc_base;
         crc_now_in      = crc_next;
         if (in_last_ff) begin
            bytes_seen_in = 2'd0;
            if (cur_mode == OP_GENERATE) begin
               pend_cnt_in = 2'd2;
               pend_pec_in = {crc_next, 1'b0};
            end
         end else if (bytes_seen_ff != 2'd3) begin
            bytes_seen_in = bytes_seen_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= SEED_RESET_VAL;
         in_valid_ff   <= 1'b0;
         bytes_seen_ff <= 2'd0;
         mode_ff       <= 1'b0;
         pend_cnt_ff   <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            seed_ff <= csr_wdata;
         end
         in_valid_ff   <= in_valid_in;
         bytes_seen_ff <= bytes_seen_in;
         mode_ff       <= mode_in;
         pend_cnt_ff   <= pend_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
         in_op_ff   <= req_operation;
      end
      if (in_move) begin
         held_byte_ff <= in_byte_ff;
      end
      crc_now_ff      <= crc_now_in;
      crc_back_one_ff <= crc_back_one_in;
      pend_pec_ff     <= pend_pec_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_pec_ff      <= rsp_pec_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_err_ff      <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_is_pec_byte = rsp_pec_ff;
   assign rsp_out_last    = rsp_last_ff;
   assign rsp_pec_fault   = rsp_err_ff;

   // The PEC queue never holds more than the two bytes of one segment.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff != 2'd3)
      else $error("PEC queue count out of range");

   // No new byte reaches the result register while PEC bytes are queued.
   a_no_overtake: assert property (@(posedge clock) disable iff (reset)
      (pend_cnt_ff != 2'd0) |-> !in_move)
      else $error("byte overtook queued PEC bytes");

   // Closing a generate-mode segment queues both PEC bytes.
   a_gen_queue: assert property (@(posedge clock) disable iff (reset)
      (in_move && in_last_ff && (cur_mode == OP_GENERATE)) |=> (pend_cnt_ff == 2'd2))
      else $error("PEC bytes not queued at segment end");

   // An appended PEC byte never carries a check error.
   a_pec_no_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_pec_byte) |-> !rsp_pec_fault)
      else $error("error flag on generated PEC byte");

endmodule
`default_nettype wire
